// ===== src/weighted_moving_average_defines.svh =====
`ifndef WEIGHTED_MOVING_AVERAGE_DEFINES_SVH
`define WEIGHTED_MOVING_AVERAGE_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define WMA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same check on the house clock and reset names.
`define WMA_ASSERT_CLK(lbl, prop, msg) `WMA_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/wma_pkg.sv =====
package wma_pkg;

  localparam int unsigned HIST_W          = 16;
  localparam int unsigned WIN_W           = 5;
  localparam int unsigned WGT_W           = 8;
  localparam int unsigned CFG_W           = 8;
  localparam int unsigned WGT_MAX         = 255;
  localparam int unsigned MAX_SAMPLES_DEF = 16;

  localparam logic [WIN_W-1:0] WINDOW_RST = 5'd4;
  localparam logic [WGT_W-1:0] WEIGHT_RST = 8'd1;

  localparam int HIST_MAX = 32767;
  localparam int HIST_MIN = -32768;
  localparam logic signed [HIST_W-1:0] AVG_MAX = 16'sh7FFF;
  localparam logic signed [HIST_W-1:0] AVG_MIN = 16'sh8000;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_FILL = 1'b1
  } wma_op_e;

  typedef enum logic {
    REG_WINDOW_LEN = 1'b0,
    REG_WEIGHT     = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_PROD,
    S_WALK,
    S_STORE,
    S_ABS,
    S_DIV,
    S_SIGN,
    S_DONE
  } wma_state_e;

  typedef struct packed {
    wma_op_e                  op;
    logic signed [HIST_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [HIST_W-1:0] average;
    logic                     div_error;
  } out_word_t;

endpackage

// ===== src/wma_hist.sv =====
module wma_hist #(
  parameter int unsigned DEPTH = wma_pkg::MAX_SAMPLES_DEF + 1,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [ADDR_W-1:0]                   waddr_i,
  input  logic signed [wma_pkg::HIST_W-1:0]   wdata_i,
  input  logic [ADDR_W-1:0]                   raddr_i,
  output logic signed [wma_pkg::HIST_W-1:0]   rdata_o
);
  import wma_pkg::*;

  logic signed [HIST_W-1:0] mem_q [DEPTH];
  logic signed [HIST_W-1:0] rdata_q;
  logic [DEPTH-1:0]         vld_q;
  logic                     rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== src/wma_alu.sv =====
module wma_alu #(
  parameter int unsigned W = 25
) (
  input  wma_pkg::alu_op_e   op_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  output logic [W-1:0]       y_o
);
  import wma_pkg::*;

  logic [W-1:0] b_eff;
  logic         cin;

  // subtract as add of the inverted operand plus one
  always_comb begin
    unique case (op_i)
      ALU_ADD: begin
        b_eff = b_i;
        cin   = 1'b0;
      end
      ALU_SUB: begin
        b_eff = ~b_i;
        cin   = 1'b1;
      end
      default: begin
        b_eff = b_i;
        cin   = 1'b0;
      end
    endcase
  end

  assign y_o = a_i + b_eff + W'(cin);

endmodule

// ===== src/weighted_moving_average.sv =====
// Weighted moving average of signed 16-bit samples.
// Input channel (in_valid_i / in_stall_o / in_word_i): a word is taken when
// valid is high and stall is low. A push word averages the new sample with
// the stored history (newest sample counted weight times); a fill word
// writes its sample into every history entry and gives no result.
// Output channel (out_valid_o / out_stall_i / out_word_o): one word per
// push, held in an output register until the receiver takes it.
// Configuration: cfg_we_i writes cfg_wdata_i into window_len (index 0) or
// weight (index 1) at the clock edge; write only while the block is idle.
// Timing: one word at a time. A push holds in_stall_o high while it walks
// the n entries of the effective window through the history's single read
// port and runs the restoring divide, one quotient bit per step on the
// shared adder over the SUM_W-bit sum (SUM_W = 25 at 16 entries); the result
// passes S_SIGN and S_DONE into the output register. A zero divisor skips
// the divide. A fill holds stall while it writes every history entry in
// turn.
// A receiver that stalls the output register keeps the finished result in
// the sequencer, and no new word is taken until it moves on.
// Reset clears the fill count, the history (through per-entry valid bits)
// and the output valid, and loads window_len = 4 and weight = 1.
`include "weighted_moving_average_defines.svh"

module weighted_moving_average #(
  parameter int unsigned MAX_SAMPLES = wma_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wma_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wma_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  wma_pkg::cfg_reg_e             cfg_idx_i,
  input  logic [wma_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import wma_pkg::*;

  localparam int unsigned DEPTH  = MAX_SAMPLES + 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH);
  localparam int unsigned ADDR_W = CNT_W;
  localparam int unsigned CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int unsigned DIV_W  = ((CNT_W > WGT_W) ? CNT_W : WGT_W) + 1;
  // worst-case |sum| is (WGT_MAX + MAX_SAMPLES) * 2^15, plus a sign bit
  localparam int unsigned SUM_W  = HIST_W + $clog2(WGT_MAX + 1 + MAX_SAMPLES);
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);
  localparam int unsigned PROD_W = HIST_W + WGT_W + 1;

  wma_state_e state_q, state_d;

  logic [WIN_W-1:0]         window_q;
  logic [WGT_W-1:0]         weight_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic [DIV_W-1:0]         div_q, div_d;
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic                     neg_q, neg_d;
  logic                     err_q, err_d;
  logic                     out_valid_q, out_valid_d;
  out_word_t                out_q, out_d;

  logic signed [HIST_W-1:0] samp_q, samp_d;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  logic [DIV_W-1:0]         rem_q, rem_d;

  // count update and divisor for a push
  logic [CMP_W-1:0]         cnt_ext, win_ext;
  logic [CNT_W-1:0]         cnt_new;
  logic [DIV_W-1:0]         div_sum;
  logic signed [PROD_W-1:0] prod;

  // history memory port
  logic                     hist_we;
  logic [ADDR_W-1:0]        hist_waddr, hist_raddr;
  logic signed [HIST_W-1:0] hist_wdata, hist_rdata;
  logic [ADDR_W:0]          raddr_next;

  // shared adder
  alu_op_e                  alu_op;
  logic [SUM_W-1:0]         alu_a, alu_b, alu_y;
  logic [DIV_W:0]           trial;
  logic                     out_free;
  logic signed [HIST_W-1:0] avg_sat;

  wma_hist #(
    .DEPTH (DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  wma_alu #(
    .W (SUM_W)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  // The count grows by one toward the window, saturating at MAX_SAMPLES, or
  // drops straight to a smaller window. The effective window is the new count.
  always_comb begin
    cnt_ext = CMP_W'(count_q);
    win_ext = CMP_W'(window_q);
    if (win_ext > cnt_ext) begin
      cnt_new = (count_q < CNT_W'(MAX_SAMPLES)) ? count_q + 1'b1 : count_q;
    end else begin
      cnt_new = CNT_W'(window_q);
    end
    div_sum = DIV_W'(cnt_new) + DIV_W'(weight_q);
  end

  assign prod  = $signed({1'b0, weight_q}) * samp_q;
  assign trial = {rem_q, acc_q[SUM_W-1]};

  // Prefetch the entry after the next one; past the top it is never used.
  assign raddr_next = {1'b0, idx_q} + (ADDR_W + 1)'(2);

  always_comb begin
    if (acc_q > HIST_MAX) begin
      avg_sat = AVG_MAX;
    end else if (acc_q < HIST_MIN) begin
      avg_sat = AVG_MIN;
    end else begin
      avg_sat = acc_q[HIST_W-1:0];
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    div_d       = div_q;
    idx_d       = idx_q;
    step_d      = step_q;
    neg_d       = neg_q;
    err_d       = err_q;
    samp_d      = samp_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    hist_we     = 1'b0;
    hist_waddr  = idx_q;
    hist_wdata  = samp_q;
    hist_raddr  = ADDR_W'(1);

    alu_op      = ALU_ADD;
    alu_a       = acc_q;
    alu_b       = SUM_W'(hist_rdata);

    // drop the held word once the receiver takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          samp_d = in_word_i.sample;
          idx_d  = '0;
          if (in_word_i.op == OP_FILL) begin
            state_d = S_FILL;
          end else begin
            state_d = S_PROD;
          end
        end
      end

      // write the fill value into one entry per cycle
      S_FILL: begin
        hist_we = 1'b1;
        if (idx_q == ADDR_W'(MAX_SAMPLES)) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // settle the count, seed the sum with weight * sample, fetch entry 1
      S_PROD: begin
        count_d    = cnt_new;
        n_d        = cnt_new;
        div_d      = div_sum;
        err_d      = (div_sum == '0);
        acc_d      = SUM_W'(prod);
        idx_d      = '0;
        hist_raddr = ADDR_W'(1);
        if (cnt_new == '0) begin
          state_d = S_STORE;
        end else begin
          state_d = S_WALK;
        end
      end

      // entry idx+1 arrives: move it down one place and add it
      S_WALK: begin
        hist_we    = 1'b1;
        hist_wdata = hist_rdata;
        hist_raddr = (raddr_next > (ADDR_W + 1)'(MAX_SAMPLES)) ? '0 : raddr_next[ADDR_W-1:0];
        acc_d      = alu_y;
        if ((idx_q + 1'b1) == n_q) begin
          state_d = S_STORE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // newest sample goes to the top of the window
      S_STORE: begin
        hist_we    = 1'b1;
        hist_waddr = n_q;
        if (err_q) begin
          acc_d   = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_ABS;
        end
      end

      // divide on magnitudes, remember the sign
      S_ABS: begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = acc_q;
        neg_d  = acc_q[SUM_W-1];
        if (acc_q[SUM_W-1]) begin
          acc_d = alu_y;
        end
        rem_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end

      // one restoring step per cycle; quotient bits shift into acc
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = SUM_W'(trial);
        alu_b  = SUM_W'(div_q);
        if (!alu_y[SUM_W-1]) begin
          rem_d = alu_y[DIV_W-1:0];
          acc_d = {acc_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = trial[DIV_W-1:0];
          acc_d = {acc_q[SUM_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = S_SIGN;
        end
      end

      // truncation toward zero: negate the magnitude quotient if the sum was negative
      S_SIGN: begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = acc_q;
        if (neg_q) begin
          acc_d = alu_y;
        end
        state_d = S_DONE;
      end

      // hold the result until the output register is free
      S_DONE: begin
        if (out_free) begin
          out_d.average   = avg_sat;
          out_d.div_error = err_q;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= WINDOW_RST;
      weight_q    <= WEIGHT_RST;
      count_q     <= '0;
      n_q         <= '0;
      div_q       <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      neg_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      div_q       <= div_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      neg_q       <= neg_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WINDOW_LEN: window_q <= cfg_wdata_i[WIN_W-1:0];
          REG_WEIGHT:     weight_q <= cfg_wdata_i[WGT_W-1:0];
          default:        window_q <= window_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= samp_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `WMA_ASSERT_CLK(a_cnt_max, count_q <= CNT_W'(MAX_SAMPLES), "fill count above depth")
  `WMA_ASSERT_CLK(a_walk_idx, state_q == S_WALK |-> idx_q < n_q, "walk past window")
  `WMA_ASSERT_CLK(a_err_zero, out_valid_q && out_q.div_error |-> out_q.average == '0,
                  "error word with nonzero average")
  `WMA_ASSERT_CLK(a_load_done, $rose(out_valid_q) |-> $past(state_q) == S_DONE,
                  "result loaded outside done state")
  `WMA_ASSERT_CLK(a_div_err, state_q == S_PROD |=> err_q == (div_q == '0),
                  "error flag disagrees with divisor")

endmodule
